// ----- rtl/core/fcst_pkg.sv -----
package fcst_pkg;

    // Op codes of an input transaction
    localparam logic [1:0] OP_WRITE_POINT = 2'd0;
    localparam logic [1:0] OP_SET_FIXED   = 2'd1;
    localparam logic [1:0] OP_EVALUATE    = 2'd2;

    // Width of temperatures and speeds
    localparam int unsigned VAL_W = 16;

    typedef struct packed {
        logic [1:0]       op;
        logic [2:0]       fan;
        logic [2:0]       point;
        logic [VAL_W-1:0] temperature;
        logic [VAL_W-1:0] rpm;
    } item_t;

    typedef struct packed {
        logic [2:0]       fan_out;
        logic [VAL_W-1:0] target_speed;
    } result_t;

    // One stored curve point
    typedef struct packed {
        logic [VAL_W-1:0] temperature;
        logic [VAL_W-1:0] rpm;
    } point_t;

endpackage

// ----- rtl/core/fcst_div.sv -----
module fcst_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [2*fcst_pkg::VAL_W-1:0]      dividend,
    input  logic [fcst_pkg::VAL_W-1:0]        divisor,
    output logic [fcst_pkg::VAL_W-1:0]        quotient,
    output logic                              done
);

    // Restoring division, one quotient bit a cycle. The upper half of the
    // dividend must be below the divisor, so the quotient fits in VAL_W bits.
    localparam int unsigned W   = fcst_pkg::VAL_W;
    localparam int unsigned CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [W:0]       trial;
    logic             fits;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[W-1]};
        fits  = (trial >= {1'b0, divisor});
        if (fits)
        begin
            rem_next = W'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[W-1:0];
        end
    end

    // Load, step and flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg <= dividend[2*W-1:W];
                quo_reg <= dividend[W-1:0];
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- rtl/core/fan_curve_speed_table.sv -----
// Fan speed table: per fan a curve of POINTS (temperature, rpm) points in a
// synchronous memory, a mode bit and a fixed speed. A transaction is taken
// when start is high and busy is low. Writing a point or a fixed speed, and
// any ignored transaction, leaves busy low. Evaluating a fan in fixed mode
// gives its result in the cycle after acceptance. Evaluating in curve mode
// first reads the last point, then reads the curve one point per cycle
// through the single read port from the first until the segment is found;
// a temperature at or below the first point or above the last gives that
// point's rpm, else ST_MUL starts the multiply and ST_DIV waits for the
// bit-serial divider. Busy drops in the cycle the result is shown. The
// result is shown for one cycle with strobe high and must be taken then;
// there is no back-pressure.
module fan_curve_speed_table #(
    parameter int unsigned FANS   = 8,
    parameter int unsigned POINTS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fcst_pkg::item_t   item,
    output logic              strobe,
    output fcst_pkg::result_t result
);

    localparam int unsigned W       = fcst_pkg::VAL_W;
    localparam int unsigned ENTRIES = FANS * POINTS;
    localparam int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned FW      = (FANS > 1) ? $clog2(FANS) : 1;
    localparam int unsigned PW      = $clog2(POINTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DIV
    } state_t;

    state_t state_reg;

    // Curve memory and its per-entry valid bits
    fcst_pkg::point_t curve_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    fcst_pkg::point_t   rdata_reg;
    logic               rvalid_reg;

    logic [FANS-1:0]    mode_reg;
    logic [W-1:0]       fixed_reg [FANS];

    // Evaluation context
    logic [2:0]         fan_reg;
    logic [W-1:0]       temp_reg;
    logic [AW-1:0]      base_reg;
    logic [PW-1:0]      idx_reg;
    logic [W-1:0]       last_t_reg;
    logic [W-1:0]       last_r_reg;
    logic [W-1:0]       prev_t_reg;
    logic [W-1:0]       prev_r_reg;
    logic [W-1:0]       a_reg;
    logic [W-1:0]       b_reg;
    logic [W-1:0]       den_reg;
    logic               neg_reg;

    logic               strobe_reg;
    fcst_pkg::result_t  result_reg;

    logic               accept;
    logic [FW-1:0]      fan_idx;
    logic               fan_ok;
    logic               point_ok;
    logic [AW-1:0]      in_base;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    fcst_pkg::point_t   entry;
    logic               at_last;
    logic               div_start;
    logic [2*W-1:0]     product;
    logic [W-1:0]       quotient;
    logic               div_done;

    // Decode the incoming transaction
    always_comb
    begin
        accept   = start && (state_reg == ST_IDLE);
        fan_idx  = FW'(item.fan);
        fan_ok   = (32'(item.fan) < FANS);
        point_ok = (32'(item.point) < POINTS);
        in_base  = AW'(32'(fan_idx) * POINTS);
        wr_en    = accept && fan_ok && point_ok && (item.op == fcst_pkg::OP_WRITE_POINT);
        wr_addr  = AW'(in_base + AW'(item.point));
        entry    = rvalid_reg ? rdata_reg : '0;
        at_last  = (idx_reg == PW'(POINTS - 1));
    end

    // Choose the next curve read: last point first, then from the first point
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = AW'(base_reg + AW'(idx_reg) + 1'b1);
        if (accept)
        begin
            rd_en   = fan_ok && (item.op == fcst_pkg::OP_EVALUATE) && mode_reg[fan_idx];
            rd_addr = AW'(in_base + AW'(POINTS - 1));
        end
        else if (state_reg == ST_LAST)
        begin
            rd_en   = 1'b1;
            rd_addr = base_reg;
        end
        else if (state_reg == ST_SCAN)
        begin
            rd_en = !at_last;
        end
    end

    // Curve memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            curve_mem[wr_addr] <= '{temperature: item.temperature, rpm: item.rpm};
        end
        if (rd_en)
        begin
            rdata_reg <= curve_mem[rd_addr];
        end
    end

    assign div_start = (state_reg == ST_MUL);
    assign product   = (2*W)'(a_reg) * (2*W)'(b_reg);

    // Divide the product by the segment width
    fcst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (den_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Sequencer, table state and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            mode_reg   <= '0;
            for (int i = 0; i < FANS; i++)
            begin
                fixed_reg[i] <= '0;
            end
            strobe_reg <= 1'b0;
            result_reg <= '0;
            fan_reg    <= '0;
            temp_reg   <= '0;
            base_reg   <= '0;
            idx_reg    <= '0;
            last_t_reg <= '0;
            last_r_reg <= '0;
            prev_t_reg <= '0;
            prev_r_reg <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            den_reg    <= '0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && fan_ok)
                    begin
                        fan_reg  <= item.fan;
                        temp_reg <= item.temperature;
                        base_reg <= in_base;
                        idx_reg  <= '0;
                        unique case (item.op)
                            fcst_pkg::OP_WRITE_POINT:
                            begin
                                if (point_ok)
                                begin
                                    mode_reg[fan_idx] <= 1'b1;
                                end
                            end
                            fcst_pkg::OP_SET_FIXED:
                            begin
                                fixed_reg[fan_idx] <= item.rpm;
                                mode_reg[fan_idx]  <= 1'b0;
                            end
                            fcst_pkg::OP_EVALUATE:
                            begin
                                if (mode_reg[fan_idx])
                                begin
                                    state_reg <= ST_LAST;
                                end
                                else
                                begin
                                    strobe_reg              <= 1'b1;
                                    result_reg.fan_out      <= item.fan;
                                    result_reg.target_speed <= fixed_reg[fan_idx];
                                end
                            end
                            default:
                            begin
                                // unused op code: drop
                            end
                        endcase
                    end
                end

                ST_LAST:
                begin
                    // Hold the last point for the above-range check
                    last_t_reg <= entry.temperature;
                    last_r_reg <= entry.rpm;
                    state_reg  <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    // At or below the first point take its rpm; above the last
                    // point take the last rpm; otherwise the first point at or
                    // above the temperature ends the search
                    if ((temp_reg <= entry.temperature) && (idx_reg != '0))
                    begin
                        // temperature lies above the lower point, so the
                        // segment width is never zero here
                        a_reg   <= temp_reg - prev_t_reg;
                        den_reg <= entry.temperature - prev_t_reg;
                        if (entry.rpm >= prev_r_reg)
                        begin
                            b_reg   <= entry.rpm - prev_r_reg;
                            neg_reg <= 1'b0;
                        end
                        else
                        begin
                            b_reg   <= prev_r_reg - entry.rpm;
                            neg_reg <= 1'b1;
                        end
                        state_reg <= ST_MUL;
                    end
                    else if (temp_reg <= entry.temperature)
                    begin
                        strobe_reg              <= 1'b1;
                        result_reg.fan_out      <= fan_reg;
                        result_reg.target_speed <= entry.rpm;
                        state_reg               <= ST_IDLE;
                    end
                    else if ((temp_reg > last_t_reg) || at_last)
                    begin
                        strobe_reg              <= 1'b1;
                        result_reg.fan_out      <= fan_reg;
                        result_reg.target_speed <= last_r_reg;
                        state_reg               <= ST_IDLE;
                    end
                    else
                    begin
                        prev_t_reg <= entry.temperature;
                        prev_r_reg <= entry.rpm;
                        idx_reg    <= idx_reg + 1'b1;
                    end
                end

                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    // Apply the truncated quotient to the rpm of the lower point
                    if (div_done)
                    begin
                        strobe_reg         <= 1'b1;
                        result_reg.fan_out <= fan_reg;
                        if (neg_reg)
                        begin
                            result_reg.target_speed <= prev_r_reg - quotient;
                        end
                        else
                        begin
                            result_reg.target_speed <= prev_r_reg + quotient;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
